### sv/tdo_pkg.sv
// ----------------------------------------------------------------------------
// tdo_pkg
// Shared types, constants and helpers of the torque disturbance observer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdo_pkg;

  localparam int AXES = 3;
  localparam int AXW  = 2;

  localparam logic [32:0]  SQRT2_Q30  = 33'd1518500250;
  localparam logic [19:0]  US_PER_SEC = 20'd1000000;

  typedef enum logic [3:0] {
    REG_CUTOFF     = 4'd0,
    REG_INERTIA_R  = 4'd1,
    REG_INERTIA_P  = 4'd2,
    REG_INERTIA_Y  = 4'd3,
    REG_LIMIT      = 4'd4,
    REG_SLEW       = 4'd5,
    REG_DEFAULT_IV = 4'd6,
    REG_CLEAR_EN   = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    SH_FRAC,
    SH_30,
    SH_32
  } shift_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DT,
    ST_WC2,
    ST_A1,
    ST_PREP,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_JW,
    ST_YM,
    ST_YQ,
    ST_SLEW,
    ST_COMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                kind;
    logic                enable_value;
    logic                gyro_valid;
    logic [15:0]         interval_us;
    logic signed [31:0]  torque_roll;
    logic signed [31:0]  torque_pitch;
    logic signed [31:0]  torque_yaw;
    logic signed [31:0]  rate_roll;
    logic signed [31:0]  rate_pitch;
    logic signed [31:0]  rate_yaw;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  cmd_roll;
    logic signed [31:0]  cmd_pitch;
    logic signed [31:0]  cmd_yaw;
    logic signed [31:0]  est_roll;
    logic signed [31:0]  est_pitch;
    logic signed [31:0]  est_yaw;
    logic signed [31:0]  used_roll;
    logic signed [31:0]  used_pitch;
    logic signed [31:0]  used_yaw;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [32:0] b;
    shift_e             sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [63:0] res;
  } mul_rsp_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic fits32(input logic signed [63:0] v);
    return (v <= 64'sd2147483647) && (v >= -64'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/tdo_chan_if.sv
// ----------------------------------------------------------------------------
// tdo_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdo_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/tdo_mul.sv
// ----------------------------------------------------------------------------
// tdo_mul
// Bit-serial sign-magnitude multiplier with truncating shift and 2^60 clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tdo_mul
  import tdo_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [95:0] p_q;
  logic [63:0] ma_q;
  logic        neg_q;
  shift_e      sh_q;

  logic [63:0] ma;
  logic [32:0] mb;
  logic [64:0] sum;
  logic [95:0] r96;
  logic        ovf;
  logic [60:0] mag;

  assign ma  = req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
  assign mb  = req_i.b[32] ? 33'(-req_i.b) : 33'(req_i.b);
  assign sum = p_q[0] ? {1'b0, p_q[95:32]} + {1'b0, ma_q} : {1'b0, p_q[95:32]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle, product grows in from the top
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      p_q   <= {64'd0, mb[31:0]};
      ma_q  <= ma;
      neg_q <= req_i.a[63] ^ req_i.b[32];
      sh_q  <= req_i.sh;
    end else if (busy_q) begin
      p_q <= {sum, p_q[31:1]};
    end
  end

  always_comb begin
    unique case (sh_q)
      SH_FRAC: r96 = p_q >> FRAC_BITS;
      SH_30:   r96 = p_q >> 30;
      SH_32:   r96 = p_q >> 32;
      default: r96 = p_q >> 32;
    endcase
    ovf = (|r96[95:61]) | (r96[60] & (|r96[59:0]));
    mag = ovf ? {1'b1, 60'd0} : r96[60:0];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf;
  assign rsp_o.res  = neg_q ? -$signed({3'b000, mag}) : $signed({3'b000, mag});

endmodule

`default_nettype wire

### sv/tdo_div.sv
// ----------------------------------------------------------------------------
// tdo_div
// Restoring divider turning an interval in microseconds into Q32 seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module tdo_div
  import tdo_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] iv_i,
  output logic             done_o,
  output logic [31:0]      q_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [47:0] s_q;
  logic [19:0] rem_q;
  logic [20:0] trial;
  logic        qbit;

  assign trial = {rem_q, s_q[47]};
  assign qbit  = trial >= {1'b0, US_PER_SEC};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q   <= {iv_i, 32'd0};
      rem_q <= '0;
    end else if (busy_q) begin
      s_q   <= {s_q[46:0], qbit};
      rem_q <= qbit ? 20'(trial - {1'b0, US_PER_SEC}) : trial[19:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = s_q[31:0];

endmodule

`default_nettype wire

### sv/torque_disturbance_observer.sv
// ----------------------------------------------------------------------------
// torque_disturbance_observer
// Three-axis disturbance observer, sequenced over one bit-serial multiplier.
// ----------------------------------------------------------------------------
// a control step with gyro does one divide and 36 multiplies, the multiplies
//   all on the single serial multiplier
// control step without gyro: straight to output; enable change: no result
// one item at a time; the next is taken once the result sits in the output
//   register, which holds it until the sink takes it
// reset: registers to their documented values, filters and compensation zero
`default_nettype none

module torque_disturbance_observer
  import tdo_pkg::*;
#(
  parameter int FRAC_BITS       = 16,
  parameter int MIN_INTERVAL_US = 100,
  parameter int MAX_INTERVAL_US = 50000
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tdo_chan_if.sink   in_i,
  tdo_chan_if.source out_o,
  tdo_chan_if.sink   cfg_i
);

  state_e state_q, state_d;

  // configuration
  logic [30:0] cutoff_q, limit_q, slew_q;
  logic [30:0] inertia_q [3];
  logic [15:0] dflt_q;
  logic        clear_q;

  // control state
  logic           issued_q, path_q, active_q, have_prev_q, ovf_q, out_valid_q;
  logic [AXW-1:0] axis_q;
  logic signed [31:0] inv0_q [AXES];
  logic signed [31:0] inv1_q [AXES];
  logic signed [31:0] qp0_q  [AXES];
  logic signed [31:0] qp1_q  [AXES];
  logic signed [31:0] comp_q [AXES];

  // payload
  logic signed [31:0] tau_q [AXES];
  logic signed [31:0] rate_q [AXES];
  logic signed [31:0] cmd_q [AXES];
  logic signed [31:0] est_q [AXES];
  logic signed [31:0] used_q [AXES];
  logic [15:0]        iv_q;
  logic [31:0]        dt_q;
  logic signed [63:0] wc2_q, a1_q, p1_q, d0_q, jw_q, ym_q, step_max_q;
  logic signed [31:0] n0_q, now_q, tc_q;
  out_item_t          out_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     div_start, div_done;
  logic [31:0] div_q;

  logic in_acc, cfg_acc, out_acc, fire, last_axis;
  logic signed [31:0] x0, x1, u, tc_new, now_new, est_new, comp_new;
  logic signed [63:0] n0_full, n1_full, diff, dclip, lim, err, sm;
  logic [15:0] iv_new;
  logic        iv_bad, bad;

  tdo_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp)
  );

  tdo_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .iv_i(iv_q), .done_o(div_done), .q_o(div_q)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign in_acc      = in_i.valid & in_i.ready;
  assign cfg_acc     = cfg_i.valid;
  assign out_acc     = out_valid_q & out_o.ready;
  assign fire        = issued_q & mrsp.done;
  assign last_axis   = (axis_q == AXW'(AXES - 1));

  // head of the rotating state lines is the axis in work
  assign x0 = path_q ? qp0_q[0] : inv0_q[0];
  assign x1 = path_q ? qp1_q[0] : inv1_q[0];
  assign u  = path_q ? (active_q ? tc_q : tau_q[0]) : rate_q[0];

  assign iv_bad = !have_prev_q || (in_i.data.interval_us < 16'(MIN_INTERVAL_US))
                  || (in_i.data.interval_us > 16'(MAX_INTERVAL_US));
  assign iv_new = iv_bad ? dflt_q : in_i.data.interval_us;

  assign now_new = active_q ? comp_q[0] : 32'sd0;
  assign tc_new  = sat32(sx64(tau_q[0]) - sx64(now_new));
  assign n0_full = sx64(x0) + mrsp.res;
  assign n1_full = sx64(x1) + mrsp.res;

  // estimate from the output difference
  always_comb begin
    diff  = ym_q - mrsp.res;
    lim   = {33'd0, limit_q};
    bad   = ovf_q | mrsp.ovf | !fits32(diff);
    dclip = bad ? 64'sd0 : diff;
    if (dclip > lim) begin
      dclip = lim;
    end else if (dclip < -lim) begin
      dclip = -lim;
    end
    est_new = dclip[31:0];
  end

  // slew-limited compensation
  always_comb begin
    sm  = step_max_q;
    err = sx64(est_q[0]) - sx64(comp_q[0]);
    if (err > sm) begin
      err = sm;
    end else if (err < -sm) begin
      err = -sm;
    end
    comp_new = active_q ? comp_q[0] + err[31:0] : 32'sd0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !in_i.data.kind) begin
          state_d = in_i.data.gyro_valid ? ST_DT : ST_OUT;
        end
      end
      ST_DT:   if (div_done) state_d = ST_WC2;
      ST_WC2:  if (fire) state_d = ST_A1;
      ST_A1:   if (fire) state_d = ST_PREP;
      ST_PREP: state_d = ST_P1;
      ST_P1:   if (fire) state_d = ST_P2;
      ST_P2:   if (fire) state_d = ST_P3;
      ST_P3:   if (fire) state_d = ST_P4;
      ST_P4:   if (fire) state_d = path_q ? ST_JW : ST_P1;
      ST_JW:   if (fire) state_d = ST_YM;
      ST_YM:   if (fire) state_d = ST_YQ;
      ST_YQ:   if (fire) state_d = last_axis ? ST_SLEW : ST_PREP;
      ST_SLEW: if (fire) state_d = ST_COMP;
      ST_COMP: if (last_axis) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // multiplier and divider requests
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.sh    = SH_FRAC;
    div_start  = 1'b0;
    unique case (state_q)
      ST_DT: div_start = !issued_q;
      ST_WC2: begin
        mreq.a = {33'd0, cutoff_q};
        mreq.b = {2'b00, cutoff_q};
      end
      ST_A1: begin
        mreq.a  = {33'd0, cutoff_q};
        mreq.b  = SQRT2_Q30;
        mreq.sh = SH_30;
      end
      ST_P1: begin
        mreq.a = a1_q;
        mreq.b = {x0[31], x0};
      end
      ST_P2: begin
        mreq.a = wc2_q;
        mreq.b = {x1[31], x1};
      end
      ST_P3: begin
        mreq.a  = d0_q;
        mreq.b  = {1'b0, dt_q};
        mreq.sh = SH_32;
      end
      ST_P4: begin
        mreq.a  = sx64(x0);
        mreq.b  = {1'b0, dt_q};
        mreq.sh = SH_32;
      end
      ST_JW: begin
        mreq.a = wc2_q;
        mreq.b = {2'b00, inertia_q[axis_q]};
      end
      ST_YM: begin
        mreq.a = jw_q;
        mreq.b = {inv0_q[0][31], inv0_q[0]};
      end
      ST_YQ: begin
        mreq.a = wc2_q;
        mreq.b = {qp1_q[0][31], qp1_q[0]};
      end
      ST_SLEW: begin
        mreq.a  = {33'd0, slew_q};
        mreq.b  = {1'b0, dt_q};
        mreq.sh = SH_32;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
    if (state_q == ST_WC2 || state_q == ST_A1 || state_q == ST_P1 || state_q == ST_P2
        || state_q == ST_P3 || state_q == ST_P4 || state_q == ST_JW || state_q == ST_YM
        || state_q == ST_YQ || state_q == ST_SLEW) begin
      mreq.start = !issued_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q     <= 31'd655360;
      inertia_q[0] <= 31'd23599;
      inertia_q[1] <= 31'd23639;
      inertia_q[2] <= 31'd43300;
      limit_q      <= 31'd655360;
      slew_q       <= 31'd327680;
      dflt_q       <= 16'd2500;
      clear_q      <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_i.data.index)
        REG_CUTOFF:     cutoff_q     <= cfg_i.data.wdata[30:0];
        REG_INERTIA_R:  inertia_q[0] <= cfg_i.data.wdata[30:0];
        REG_INERTIA_P:  inertia_q[1] <= cfg_i.data.wdata[30:0];
        REG_INERTIA_Y:  inertia_q[2] <= cfg_i.data.wdata[30:0];
        REG_LIMIT:      limit_q      <= cfg_i.data.wdata[30:0];
        REG_SLEW:       slew_q       <= cfg_i.data.wdata[30:0];
        REG_DEFAULT_IV: dflt_q       <= cfg_i.data.wdata[15:0];
        REG_CLEAR_EN:   clear_q      <= cfg_i.data.wdata[0];
        default:        clear_q      <= clear_q;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      path_q      <= 1'b0;
      active_q    <= 1'b0;
      have_prev_q <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      axis_q      <= '0;
      for (int k = 0; k < AXES; k++) begin
        inv0_q[k] <= '0;
        inv1_q[k] <= '0;
        qp0_q[k]  <= '0;
        qp1_q[k]  <= '0;
        comp_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (mreq.start || div_start) begin
        issued_q <= 1'b1;
      end else if (fire || div_done) begin
        issued_q <= 1'b0;
      end
      // a new result may replace one taken in the same cycle
      if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          axis_q <= '0;
          if (in_acc && in_i.data.kind) begin
            if (in_i.data.enable_value != active_q) begin
              active_q <= in_i.data.enable_value;
              for (int k = 0; k < AXES; k++) comp_q[k] <= '0;
              if (in_i.data.enable_value && clear_q) begin
                have_prev_q <= 1'b0;
                for (int k = 0; k < AXES; k++) begin
                  inv0_q[k] <= '0;
                  inv1_q[k] <= '0;
                  qp0_q[k]  <= '0;
                  qp1_q[k]  <= '0;
                end
              end
            end
          end else if (in_acc && in_i.data.gyro_valid) begin
            have_prev_q <= 1'b1;
          end
        end
        ST_PREP: begin
          ovf_q  <= 1'b0;
          path_q <= 1'b0;
        end
        ST_P1, ST_P2, ST_JW, ST_YM: if (fire) ovf_q <= ovf_q | mrsp.ovf;
        ST_P3: if (fire) ovf_q <= ovf_q | mrsp.ovf | !fits32(n0_full);
        ST_P4: begin
          if (fire) begin
            ovf_q  <= ovf_q | mrsp.ovf | !fits32(n1_full);
            path_q <= 1'b1;
            if (path_q) begin
              qp0_q[0] <= n0_q;
              qp1_q[0] <= sat32(n1_full);
            end else begin
              inv0_q[0] <= n0_q;
              inv1_q[0] <= sat32(n1_full);
            end
          end
        end
        ST_YQ: begin
          if (fire) begin
            axis_q <= last_axis ? '0 : axis_q + AXW'(1);
            for (int k = 0; k < AXES - 1; k++) begin
              inv0_q[k] <= inv0_q[k+1];
              inv1_q[k] <= inv1_q[k+1];
              qp0_q[k]  <= qp0_q[k+1];
              qp1_q[k]  <= qp1_q[k+1];
              comp_q[k] <= comp_q[k+1];
            end
            inv0_q[AXES-1] <= inv0_q[0];
            inv1_q[AXES-1] <= inv1_q[0];
            qp0_q[AXES-1]  <= qp0_q[0];
            qp1_q[AXES-1]  <= qp1_q[0];
            comp_q[AXES-1] <= comp_q[0];
          end
        end
        ST_COMP: begin
          axis_q <= last_axis ? '0 : axis_q + AXW'(1);
          for (int k = 0; k < AXES - 1; k++) comp_q[k] <= comp_q[k+1];
          comp_q[AXES-1] <= comp_new;
        end
        default: begin
          ovf_q <= ovf_q;
        end
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !in_i.data.kind) begin
          tau_q[0]  <= in_i.data.torque_roll;
          tau_q[1]  <= in_i.data.torque_pitch;
          tau_q[2]  <= in_i.data.torque_yaw;
          rate_q[0] <= in_i.data.rate_roll;
          rate_q[1] <= in_i.data.rate_pitch;
          rate_q[2] <= in_i.data.rate_yaw;
          iv_q      <= iv_new;
          cmd_q[0]  <= in_i.data.torque_roll;
          cmd_q[1]  <= in_i.data.torque_pitch;
          cmd_q[2]  <= in_i.data.torque_yaw;
          for (int k = 0; k < AXES; k++) begin
            est_q[k]  <= '0;
            used_q[k] <= '0;
          end
        end
      end
      ST_DT:   if (div_done) dt_q <= div_q;
      ST_WC2:  if (fire) wc2_q <= mrsp.res;
      ST_A1:   if (fire) a1_q <= mrsp.res;
      ST_PREP: begin
        now_q <= now_new;
        tc_q  <= tc_new;
      end
      ST_P1:   if (fire) p1_q <= mrsp.res;
      ST_P2:   if (fire) d0_q <= sx64(u) - p1_q - mrsp.res;
      ST_P3:   if (fire) n0_q <= sat32(n0_full);
      ST_JW:   if (fire) jw_q <= mrsp.res;
      ST_YM:   if (fire) ym_q <= mrsp.res;
      ST_YQ: begin
        if (fire) begin
          for (int k = 0; k < AXES - 1; k++) begin
            tau_q[k]  <= tau_q[k+1];
            rate_q[k] <= rate_q[k+1];
            cmd_q[k]  <= cmd_q[k+1];
            est_q[k]  <= est_q[k+1];
            used_q[k] <= used_q[k+1];
          end
          tau_q[AXES-1]  <= tau_q[0];
          rate_q[AXES-1] <= rate_q[0];
          cmd_q[AXES-1]  <= tc_q;
          est_q[AXES-1]  <= est_new;
          used_q[AXES-1] <= now_q;
        end
      end
      ST_SLEW: if (fire) step_max_q <= mrsp.res;
      ST_COMP: begin
        for (int k = 0; k < AXES - 1; k++) est_q[k] <= est_q[k+1];
        est_q[AXES-1] <= est_q[0];
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_q.cmd_roll   <= cmd_q[0];
          out_q.cmd_pitch  <= cmd_q[1];
          out_q.cmd_yaw    <= cmd_q[2];
          out_q.est_roll   <= est_q[0];
          out_q.est_pitch  <= est_q[1];
          out_q.est_yaw    <= est_q[2];
          out_q.used_roll  <= used_q[0];
          out_q.used_pitch <= used_q[1];
          out_q.used_yaw   <= used_q[2];
        end
      end
      default: begin
        iv_q <= iv_q;
      end
    endcase
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the torque disturbance observer: directed and
// random steps, enable changes and register settings, checked against a
// fixed-point predictor of the observer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tdo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int MIN_IV = 100;
  localparam int MAX_IV = 50000;
  localparam longint PROD_CAP = 64'sd1 << 60;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tdo_chan_if #(.T(in_item_t))  step_if ();
  tdo_chan_if #(.T(out_item_t)) res_if ();
  tdo_chan_if #(.T(cfg_item_t)) cfg_if ();

  torque_disturbance_observer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (step_if.sink),
    .out_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  // observer copy of registers and state
  longint wc_reg, lim_reg, slew_reg, div_reg;
  longint inertia_reg [3];
  bit     clear_reg;
  longint qx [6];
  longint mx [6];
  longint comp [3];
  bit     obs_on, have_prev;

  in_item_t  pending_q [$];
  out_item_t expected_q [$];
  int        n_errors = 0;
  int        send_idle_pct = 9, recv_idle_pct = 46;
  bit        recv_hold = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  bit        step_taken = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v, ref bit ovf);
    if (v > S32_MAX) begin
      ovf = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      ovf = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // exact product, shifted, truncated toward zero, capped at 2^60
  function automatic longint prod_shift(longint a, longint b, int sh, ref bit ovf);
    bit neg;
    logic [127:0] p;
    logic [127:0] r;
    neg = (a < 0) != (b < 0);
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    r = p >> sh;
    if (r > 128'(PROD_CAP)) begin
      ovf = 1'b1;
      r = 128'(PROD_CAP);
    end
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic void euler_step(ref longint x [6], input int base, longint u,
                                     longint a1, longint wc2, longint dt,
                                     ref bit ovf);
    longint x0, x1, d0, n0, n1;
    x0 = x[base];
    x1 = x[base+1];
    d0 = u - prod_shift(a1, x0, FRAC, ovf) - prod_shift(wc2, x1, FRAC, ovf);
    n0 = x0 + prod_shift(d0, dt, 32, ovf);
    n1 = x1 + prod_shift(x0, dt, 32, ovf);
    x[base] = clamp32(n0, ovf);
    x[base+1] = clamp32(n1, ovf);
  endfunction

  function automatic void observe_reset();
    wc_reg = 655360;
    inertia_reg[0] = 23599;
    inertia_reg[1] = 23639;
    inertia_reg[2] = 43300;
    lim_reg = 655360;
    slew_reg = 327680;
    div_reg = 2500;
    clear_reg = 1'b0;
    foreach (qx[k]) begin
      qx[k] = 0;
      mx[k] = 0;
    end
    foreach (comp[k]) comp[k] = 0;
    obs_on = 1'b0;
    have_prev = 1'b0;
  endfunction

  function automatic void observe_step(in_item_t it);
    longint tq [3], rt [3], cmd [3], est [3], used [3];
    longint iv, dt, wc2, a1, step_max, now_c, tc, jw, ym, yq, diff, err;
    logic [63:0] num;
    bit ovf, dummy;
    out_item_t r;
    tq[0] = it.torque_roll;
    tq[1] = it.torque_pitch;
    tq[2] = it.torque_yaw;
    rt[0] = it.rate_roll;
    rt[1] = it.rate_pitch;
    rt[2] = it.rate_yaw;
    if (it.kind) begin
      if (it.enable_value != obs_on) begin
        obs_on = it.enable_value;
        foreach (comp[k]) comp[k] = 0;
        if (obs_on && clear_reg) begin
          foreach (qx[k]) begin
            qx[k] = 0;
            mx[k] = 0;
          end
          have_prev = 1'b0;
        end
      end
      return;
    end
    if (!it.gyro_valid) begin
      for (int k = 0; k < 3; k++) begin
        cmd[k] = tq[k];
        est[k] = 0;
        used[k] = 0;
      end
    end else begin
      dummy = 1'b0;
      iv = it.interval_us;
      if (!have_prev || iv < MIN_IV || iv > MAX_IV) iv = div_reg;
      have_prev = 1'b1;
      num = 64'(iv) << 32;
      dt = longint'(num / 64'd1000000);
      wc2 = (wc_reg * wc_reg) >>> FRAC;
      a1 = longint'((128'(wc_reg) * 128'(SQRT2_Q30)) >> 30);
      for (int k = 0; k < 3; k++) begin
        ovf = 1'b0;
        now_c = obs_on ? comp[k] : 0;
        tc = clamp32(tq[k] - now_c, dummy);
        euler_step(mx, 2*k, rt[k], a1, wc2, dt, ovf);
        euler_step(qx, 2*k, obs_on ? tc : tq[k], a1, wc2, dt, ovf);
        jw = prod_shift(inertia_reg[k], wc2, FRAC, ovf);
        ym = prod_shift(jw, mx[2*k], FRAC, ovf);
        yq = prod_shift(wc2, qx[2*k+1], FRAC, ovf);
        diff = ym - yq;
        if (ovf || diff > S32_MAX || diff < S32_MIN) diff = 0;
        if (diff > lim_reg) diff = lim_reg;
        if (diff < -lim_reg) diff = -lim_reg;
        cmd[k] = tc;
        est[k] = diff;
        used[k] = now_c;
      end
      step_max = prod_shift(slew_reg, dt, 32, dummy);
      for (int k = 0; k < 3; k++) begin
        if (!obs_on) begin
          comp[k] = 0;
        end else begin
          err = est[k] - comp[k];
          if (err > step_max) err = step_max;
          if (err < -step_max) err = -step_max;
          comp[k] = longint'(signed'(32'(comp[k] + err)));
        end
      end
    end
    r.cmd_roll = 32'(cmd[0]);
    r.cmd_pitch = 32'(cmd[1]);
    r.cmd_yaw = 32'(cmd[2]);
    r.est_roll = 32'(est[0]);
    r.est_pitch = 32'(est[1]);
    r.est_yaw = 32'(est[2]);
    r.used_roll = 32'(used[0]);
    r.used_pitch = 32'(used[1]);
    r.used_yaw = 32'(used[2]);
    expected_q.push_back(r);
  endfunction

  function automatic void write_register(reg_idx_e idx, logic [31:0] v);
    case (idx)
      REG_CUTOFF:     wc_reg = v[30:0];
      REG_INERTIA_R:  inertia_reg[0] = v[30:0];
      REG_INERTIA_P:  inertia_reg[1] = v[30:0];
      REG_INERTIA_Y:  inertia_reg[2] = v[30:0];
      REG_LIMIT:      lim_reg = v[30:0];
      REG_SLEW:       slew_reg = v[30:0];
      REG_DEFAULT_IV: div_reg = v[15:0];
      REG_CLEAR_EN:   clear_reg = v[0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what,
             $signed(got), $signed(want));
    n_errors++;
  endtask

  // driver: offers pending items at the falling edge
  always @(negedge clk_i) begin
    bit keep;
    if (rst_ni) begin
      keep = step_if.valid && !step_taken;
      if (step_taken) begin
        void'(pending_q.pop_front());
        step_taken = 1'b0;
      end
      if (pending_q.size() > 0 && (keep || $urandom_range(99) >= send_idle_pct)) begin
        step_if.valid <= 1'b1;
        step_if.data  <= pending_q[0];
      end else begin
        step_if.valid <= 1'b0;
      end
      res_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // transfers are seen at the rising edge and predicted there
  always @(posedge clk_i) begin
    if (rst_ni && step_if.valid && step_if.ready) begin
      observe_step(step_if.data);
      step_taken = 1'b1;
    end
  end

  // long receiver stall, counted here while the sender keeps offering
  initial begin
    wait (hold_req);
    recv_hold = 1'b1;
    repeat (4000) @(posedge clk_i);
    recv_hold = 1'b0;
    hold_done = 1'b1;
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (expected_q.size() == 0) begin
        $display("result with nothing expected");
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.cmd_roll !== want.cmd_roll)
          report_mismatch("cmd_roll", got.cmd_roll, want.cmd_roll);
        if (got.cmd_pitch !== want.cmd_pitch)
          report_mismatch("cmd_pitch", got.cmd_pitch, want.cmd_pitch);
        if (got.cmd_yaw !== want.cmd_yaw)
          report_mismatch("cmd_yaw", got.cmd_yaw, want.cmd_yaw);
        if (got.est_roll !== want.est_roll)
          report_mismatch("est_roll", got.est_roll, want.est_roll);
        if (got.est_pitch !== want.est_pitch)
          report_mismatch("est_pitch", got.est_pitch, want.est_pitch);
        if (got.est_yaw !== want.est_yaw)
          report_mismatch("est_yaw", got.est_yaw, want.est_yaw);
        if (got.used_roll !== want.used_roll)
          report_mismatch("used_roll", got.used_roll, want.used_roll);
        if (got.used_pitch !== want.used_pitch)
          report_mismatch("used_pitch", got.used_pitch, want.used_pitch);
        if (got.used_yaw !== want.used_yaw)
          report_mismatch("used_yaw", got.used_yaw, want.used_yaw);
      end
    end
  end

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return 32'(signed'($urandom_range(20 * 65536)) - 10 * 65536);
      1: return $urandom();
      2: return 32'h7fffffff;
      default: return 32'h80000000;
    endcase
  endfunction

  function automatic in_item_t make_step(bit gyro, logic [15:0] iv, int mode);
    in_item_t it;
    it = '0;
    it.kind = 1'b0;
    it.enable_value = 1'($urandom_range(1));
    it.gyro_valid = gyro;
    it.interval_us = iv;
    it.torque_roll = rand_word(mode);
    it.torque_pitch = rand_word(mode);
    it.torque_yaw = rand_word(mode);
    it.rate_roll = rand_word(mode);
    it.rate_pitch = rand_word(mode);
    it.rate_yaw = rand_word(mode);
    return it;
  endfunction

  function automatic in_item_t make_enable(bit en);
    in_item_t it;
    it = make_step(1'($urandom_range(1)), 16'($urandom()), 1);
    it.kind = 1'b1;
    it.enable_value = en;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || step_if.valid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
  endtask

  task automatic config_write(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, wdata: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    write_register(idx, v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        pending_q.push_back(make_enable(1'($urandom_range(1))));
      end else if (pick < 12) begin
        pending_q.push_back(make_step(1'b0, 16'($urandom()), 1));
      end else if (pick < 20) begin
        pending_q.push_back(make_step(1'b1, 16'($urandom()), $urandom_range(3)));
      end else begin
        pending_q.push_back(make_step(1'b1, 16'($urandom_range(MAX_IV, MIN_IV)),
                                      $urandom_range(1)));
      end
    end
  endtask

  initial begin
    step_if.valid = 1'b0;
    step_if.data = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    observe_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: disabled steps, no gyro, bad intervals, enable toggles, extremes
    pending_q.push_back(make_step(1'b0, 16'd0, 2));
    pending_q.push_back(make_step(1'b1, 16'd2500, 0));
    pending_q.push_back(make_step(1'b1, 16'd99, 0));
    pending_q.push_back(make_step(1'b1, 16'd100, 0));
    pending_q.push_back(make_step(1'b1, 16'd50000, 3));
    pending_q.push_back(make_step(1'b1, 16'd50001, 0));
    pending_q.push_back(make_enable(1'b1));
    pending_q.push_back(make_enable(1'b1));
    for (int n = 0; n < 6; n++) pending_q.push_back(make_step(1'b1, 16'd2500, 0));
    pending_q.push_back(make_step(1'b1, 16'hffff, 2));
    pending_q.push_back(make_step(1'b1, 16'd2500, 3));
    pending_q.push_back(make_step(1'b0, 16'hffff, 3));
    pending_q.push_back(make_enable(1'b0));
    pending_q.push_back(make_enable(1'b0));
    wait_drained();

    // every register, including extremes; clear on enable set
    config_write(REG_CUTOFF, 32'hffffffff);
    config_write(REG_INERTIA_R, 32'h7fffffff);
    config_write(REG_INERTIA_P, 32'd0);
    config_write(REG_INERTIA_Y, 32'd65536);
    config_write(REG_LIMIT, 32'h7fffffff);
    config_write(REG_SLEW, 32'h7fffffff);
    config_write(REG_DEFAULT_IV, 32'd1);
    config_write(REG_CLEAR_EN, 32'd1);
    pending_q.push_back(make_enable(1'b1));
    random_phase(40);
    wait_drained();

    config_write(REG_CUTOFF, 32'd0);
    config_write(REG_LIMIT, 32'd0);
    config_write(REG_SLEW, 32'd0);
    config_write(REG_DEFAULT_IV, 32'hffff);
    random_phase(20);
    wait_drained();

    config_write(REG_CUTOFF, 32'd131072 + $urandom_range(2000000));
    config_write(REG_INERTIA_R, $urandom_range(100000));
    config_write(REG_INERTIA_P, 32'd23639);
    config_write(REG_LIMIT, 32'd655360);
    config_write(REG_SLEW, 32'd327680 + $urandom_range(3000000));
    config_write(REG_DEFAULT_IV, 32'd2500);
    config_write(REG_CLEAR_EN, 32'd0);
    config_write(reg_idx_e'(4'd9), $urandom());
    random_phase(130);
    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    wait (hold_done);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 9;
    config_write(REG_CLEAR_EN, 32'd1);
    random_phase(130);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(130);
    wait_drained();

    if (n_errors == 0) begin
      $display("torque_disturbance_observer verification clean");
    end else begin
      $display("torque_disturbance_observer verification failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("torque_disturbance_observer verification failed");
    $finish;
  end

endmodule

`default_nettype wire
